### hdl/ratp_pkg.sv
// ----------------------------------------------------------------------------
// ratp_pkg - shared types and constants for the adaptive transmit power block
// Payload structs, operation and register codes, and register reset values.
// ----------------------------------------------------------------------------
package ratp_pkg;

  typedef logic signed [15:0] q88_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_RESET  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_ADAPTIVE_ENABLE = 3'd0,
    REG_CAP_INDEX       = 3'd1,
    REG_STRONG_THRESH   = 3'd2,
    REG_WEAK_THRESH     = 3'd3,
    REG_STRONG_ROUNDS   = 3'd4,
    REG_WEAK_ROUNDS     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    op_t               op;
    logic [2:0]        link_slot;
    logic signed [7:0] rssi_dbm;
    logic              round_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] power_index;
    logic       stepped;
    logic       had_reading;
  } out_item_t;

  localparam logic              ENABLE_RESET        = 1'b1;
  localparam logic [1:0]        CAP_RESET           = 2'd2;
  localparam logic signed [7:0] STRONG_THRESH_RESET = -8'sd60;
  localparam logic signed [7:0] WEAK_THRESH_RESET   = -8'sd80;
  localparam logic [7:0]        STRONG_ROUNDS_RESET = 8'd3;
  localparam logic [7:0]        WEAK_ROUNDS_RESET   = 8'd2;
  localparam logic [7:0]        COUNT_MAX           = 8'hFF;

endpackage

### hdl/ratp_avg_update.sv
// ----------------------------------------------------------------------------
// ratp_avg_update - per-link exponential average update
// Loads a first reading in Q8.8, otherwise adds a quarter of the error with
// a floor shift.
// ----------------------------------------------------------------------------
module ratp_avg_update
  import ratp_pkg::*;
(
  input  logic              has_avg,
  input  q88_t              avg_old,
  input  logic signed [7:0] rssi_dbm,
  output q88_t              avg_new
);

  q88_t               sample_q;
  logic signed [16:0] diff;
  logic signed [16:0] quarter;
  logic signed [16:0] sum;

  assign sample_q = {rssi_dbm, 8'h00};
  assign diff     = {sample_q[15], sample_q} - {avg_old[15], avg_old};
  assign quarter  = diff >>> 2;
  assign sum      = {avg_old[15], avg_old} + quarter;
  assign avg_new  = has_avg ? sum[15:0] : sample_q;

endmodule

### hdl/rssi_adaptive_tx_power.sv
// ----------------------------------------------------------------------------
// rssi_adaptive_tx_power - RSSI driven adaptive transmit power control
// Per-link averaging, round minimum, hysteresis counters and power stepping.
// ----------------------------------------------------------------------------
// Readings enter an input register and are processed from that register
// against the link averages and round state; a round-end reading writes its
// result into an output register. One reading is taken every clock cycle
// unless a stalled result holds the input side, so the block sustains one
// item per cycle; the output register is the only point where a stalled
// result holds the input side. Configuration writes are always ready and
// are expected only while the block is idle; a cap write or a reset
// operation clears the averages, counters and round state.
// ----------------------------------------------------------------------------
module rssi_adaptive_tx_power
  import ratp_pkg::*;
#(
  parameter int MAX_LINKS         = 8,
  parameter int POWER_LEVEL_COUNT = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int DEPTH = (MAX_LINKS < 8) ? MAX_LINKS : 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [1:0] eff_cap(input logic [1:0] cap);
    eff_cap = (int'(cap) < POWER_LEVEL_COUNT) ? cap : 2'd0;
  endfunction

  // configuration
  logic              enable_r;
  logic [1:0]        cap_r;
  logic signed [7:0] strong_thr_r;
  logic signed [7:0] weak_thr_r;
  logic [7:0]        strong_need_r;
  logic [7:0]        weak_need_r;
  logic              cfg_wr;
  logic              cap_wr;

  // pipeline
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      adv;
  logic      gives_result;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_load;
  out_item_t out_data_nxt;

  // state
  q88_t             avg_r [DEPTH];
  logic [DEPTH-1:0] link_has_r;
  q88_t             weakest_r;
  q88_t             weakest_nxt;
  logic             round_has_r;
  logic             round_has_nxt;
  logic [7:0]       strong_cnt_r;
  logic [7:0]       strong_cnt_nxt;
  logic [7:0]       weak_cnt_r;
  logic [7:0]       weak_cnt_nxt;
  logic [1:0]       level_r;
  logic [1:0]       level_nxt;
  logic             active_r;
  logic             active_nxt;
  logic             clear_all;
  logic [1:0]       clear_level;

  logic [1:0]       ecap;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic             avg_we;
  q88_t             avg_old;
  q88_t             avg_new;
  q88_t             strong_q;
  q88_t             weak_q;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cap_wr    = cfg_wr && (cfg_reg_t'(cfg_index) == REG_CAP_INDEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= ENABLE_RESET;
      cap_r         <= CAP_RESET;
      strong_thr_r  <= STRONG_THRESH_RESET;
      weak_thr_r    <= WEAK_THRESH_RESET;
      strong_need_r <= STRONG_ROUNDS_RESET;
      weak_need_r   <= WEAK_ROUNDS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ADAPTIVE_ENABLE: enable_r      <= cfg_data[0];
        REG_CAP_INDEX:       cap_r         <= cfg_data[1:0];
        REG_STRONG_THRESH:   strong_thr_r  <= cfg_data;
        REG_WEAK_THRESH:     weak_thr_r    <= cfg_data;
        REG_STRONG_ROUNDS:   strong_need_r <= cfg_data;
        REG_WEAK_ROUNDS:     weak_need_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ecap         = eff_cap(cap_r);
  assign gives_result = (s1_item_r.op == OP_SAMPLE) && s1_item_r.round_end;
  assign adv          = s1_valid_r && (!gives_result || !out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !adv;

  assign slot_ok  = int'(s1_item_r.link_slot) < DEPTH;
  assign slot_idx = s1_item_r.link_slot[IDX_W-1:0];
  assign avg_old  = avg_r[slot_idx];
  assign strong_q = {strong_thr_r, 8'h00};
  assign weak_q   = {weak_thr_r, 8'h00};

  ratp_avg_update u_avg (
    .has_avg  (link_has_r[slot_idx]),
    .avg_old  (avg_old),
    .rssi_dbm (s1_item_r.rssi_dbm),
    .avg_new  (avg_new)
  );

  always_comb begin
    logic       reading;
    logic [1:0] cur;
    logic [7:0] inc;
    weakest_nxt    = weakest_r;
    round_has_nxt  = round_has_r;
    strong_cnt_nxt = strong_cnt_r;
    weak_cnt_nxt   = weak_cnt_r;
    level_nxt      = level_r;
    active_nxt     = active_r;
    clear_all      = 1'b0;
    avg_we         = 1'b0;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    reading        = 1'b0;
    cur            = (level_r > ecap) ? ecap : level_r;
    inc            = 8'd0;
    if (adv) begin
      if (s1_item_r.op == OP_RESET) begin
        clear_all = 1'b1;
      end else if (!enable_r) begin
        if (s1_item_r.round_end) begin
          out_load                 = 1'b1;
          out_data_nxt.stepped     = active_r && (level_r != ecap);
          out_data_nxt.had_reading = 1'b0;
          out_data_nxt.power_index = active_r ? ecap : level_r;
          clear_all                = active_r;
          weakest_nxt              = '0;
          round_has_nxt            = 1'b0;
        end
      end else begin
        active_nxt = 1'b1;
        reading    = (s1_item_r.rssi_dbm != 8'sd0) && slot_ok;
        if (reading) begin
          avg_we = 1'b1;
          if (!round_has_r || (avg_new < weakest_r)) begin
            weakest_nxt   = avg_new;
            round_has_nxt = 1'b1;
          end
        end
        if (s1_item_r.round_end) begin
          out_load                 = 1'b1;
          out_data_nxt.stepped     = 1'b0;
          out_data_nxt.had_reading = round_has_nxt;
          if (round_has_nxt) begin
            if (weakest_nxt > strong_q) begin
              weak_cnt_nxt = '0;
              inc = (strong_cnt_r == COUNT_MAX) ? strong_cnt_r : strong_cnt_r + 8'd1;
              strong_cnt_nxt = inc;
              if (inc >= strong_need_r) begin
                strong_cnt_nxt = '0;
                if (cur > 2'd0) begin
                  level_nxt            = cur - 2'd1;
                  out_data_nxt.stepped = 1'b1;
                end
              end
            end else if (weakest_nxt < weak_q) begin
              strong_cnt_nxt = '0;
              inc = (weak_cnt_r == COUNT_MAX) ? weak_cnt_r : weak_cnt_r + 8'd1;
              weak_cnt_nxt = inc;
              if (inc >= weak_need_r) begin
                weak_cnt_nxt = '0;
                if (cur < ecap) begin
                  level_nxt            = cur + 2'd1;
                  out_data_nxt.stepped = 1'b1;
                end
              end
            end else begin
              strong_cnt_nxt = '0;
              weak_cnt_nxt   = '0;
            end
          end
          out_data_nxt.power_index = level_nxt;
          weakest_nxt              = '0;
          round_has_nxt            = 1'b0;
        end
      end
    end
  end

  assign clear_level = cap_wr ? eff_cap(cfg_data[1:0]) : ecap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (avg_we) begin
      avg_r[slot_idx] <= avg_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_has_r   <= '0;
      weakest_r    <= '0;
      round_has_r  <= 1'b0;
      strong_cnt_r <= '0;
      weak_cnt_r   <= '0;
      level_r      <= eff_cap(CAP_RESET);
      active_r     <= 1'b0;
    end else if (cap_wr || clear_all) begin
      link_has_r   <= '0;
      weakest_r    <= '0;
      round_has_r  <= 1'b0;
      strong_cnt_r <= '0;
      weak_cnt_r   <= '0;
      level_r      <= clear_level;
      active_r     <= 1'b0;
    end else begin
      if (avg_we) begin
        link_has_r[slot_idx] <= 1'b1;
      end
      weakest_r    <= weakest_nxt;
      round_has_r  <= round_has_nxt;
      strong_cnt_r <= strong_cnt_nxt;
      weak_cnt_r   <= weak_cnt_nxt;
      level_r      <= level_nxt;
      active_r     <= active_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_level_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= ecap)
    else $error("power level above effective cap");

  a_counters_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !((strong_cnt_r != 8'd0) && (weak_cnt_r != 8'd0)))
    else $error("strong and weak round counters both running");

  a_round_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    adv && gives_result |=> !round_has_r)
    else $error("round accumulator not cleared at round end");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result loaded over a stalled transfer");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for rssi_adaptive_tx_power
// Drives a stimulus table and then randomised sampling rounds under a series
// of register settings. A local predictor of the link averages, hysteresis
// counters and power level provides expected results where a table row pins
// none. Each result is checked field by field, in order. Sender bursts,
// receiver stalls and long receiver hold-offs exercise the flow control.
// ----------------------------------------------------------------------------
module tb_top;
  import ratp_pkg::*;

  localparam int LINK_SLOTS     = 8;
  localparam int LEVEL_COUNT    = 3;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef enum bit {
    ROW_READING,
    ROW_REG_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t  kind;
    in_item_t   item;
    logic [2:0] reg_idx;
    logic [7:0] reg_val;
    bit         pinned;
    out_item_t  want;
  } script_row_t;

  typedef struct {
    bit         enable;
    logic [1:0] cap;
    int         strong_thr;
    int         weak_thr;
    int         strong_need;
    int         weak_need;
    int         rssi_lo;
    int         rssi_hi;
    int         rounds;
    int         max_len;
    int         reset_pct;
  } stage_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  // Typed-in expectation travelling with the current transfer
  bit        pin_valid;
  out_item_t pin_result;

  rssi_adaptive_tx_power #(
    .MAX_LINKS        (LINK_SLOTS),
    .POWER_LEVEL_COUNT(LEVEL_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Power control state as predicted
  bit                m_enable;
  logic [1:0]        m_cap;
  logic signed [7:0] m_strong_thr;
  logic signed [7:0] m_weak_thr;
  logic [7:0]        m_strong_need;
  logic [7:0]        m_weak_need;

  q88_t       avg_mem [LINK_SLOTS];
  bit         avg_loaded [LINK_SLOTS];
  int         low_avg;
  bit         low_seen;
  int         strong_run;
  int         weak_run;
  logic [1:0] power_level;
  bit         link_active;

  out_item_t power_reports_due[$];

  int mismatches      = 0;
  int readings_in     = 0;
  int reg_writes      = 0;
  int results_seen    = 0;
  int level_steps     = 0;
  int disabled_rounds = 0;
  int burst_left      = 0;

  function automatic int cap_in_force();
    return (m_cap < LEVEL_COUNT) ? int'(m_cap) : 0;
  endfunction

  task automatic clear_link_state();
    for (int i = 0; i < LINK_SLOTS; i++) begin
      avg_mem[i]    = '0;
      avg_loaded[i] = 1'b0;
    end
    low_avg     = 0;
    low_seen    = 1'b0;
    strong_run  = 0;
    weak_run    = 0;
    power_level = 2'(cap_in_force());
    link_active = 1'b0;
  endtask

  task automatic apply_reg_write(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      REG_ADAPTIVE_ENABLE: m_enable = val[0];
      REG_CAP_INDEX: begin
        m_cap = val[1:0];
        clear_link_state();
      end
      REG_STRONG_THRESH: m_strong_thr = val;
      REG_WEAK_THRESH:   m_weak_thr = val;
      REG_STRONG_ROUNDS: m_strong_need = val;
      REG_WEAK_ROUNDS:   m_weak_need = val;
      default: ;
    endcase
  endtask

  task automatic predict_power_round(input in_item_t it, output bit due,
                                     output out_item_t res);
    int rssi_v, avg_v, cap_now, cur, strong_q88, weak_q88;
    due = 1'b0;
    res = '0;
    if (it.op == OP_RESET) begin
      clear_link_state();
      return;
    end
    cap_now = cap_in_force();
    if (!m_enable) begin
      if (!it.round_end) return;
      if (link_active) begin
        res.stepped = (int'(power_level) != cap_now);
        clear_link_state();
      end
      low_avg = 0;
      low_seen = 1'b0;
      res.power_index = power_level;
      due = 1'b1;
      disabled_rounds++;
      return;
    end
    link_active = 1'b1;
    rssi_v = $signed(it.rssi_dbm);
    if (rssi_v != 0 && it.link_slot < LINK_SLOTS) begin
      if (avg_loaded[it.link_slot]) begin
        avg_v = avg_mem[it.link_slot];
        avg_v = avg_v + ((rssi_v * 256 - avg_v) >>> 2);
      end else begin
        avg_v = rssi_v * 256;
        avg_loaded[it.link_slot] = 1'b1;
      end
      avg_mem[it.link_slot] = q88_t'(avg_v);
      if (!low_seen || avg_v < low_avg) begin
        low_avg  = avg_v;
        low_seen = 1'b1;
      end
    end
    if (!it.round_end) return;
    due = 1'b1;
    if (low_seen) begin
      res.had_reading = 1'b1;
      cur = (int'(power_level) > cap_now) ? cap_now : int'(power_level);
      strong_q88 = int'(m_strong_thr) * 256;
      weak_q88   = int'(m_weak_thr) * 256;
      if (low_avg > strong_q88) begin
        weak_run = 0;
        if (strong_run < COUNT_MAX) strong_run++;
        if (strong_run >= m_strong_need) begin
          strong_run = 0;
          if (cur > 0) begin
            power_level = 2'(cur - 1);
            res.stepped = 1'b1;
          end
        end
      end else if (low_avg < weak_q88) begin
        strong_run = 0;
        if (weak_run < COUNT_MAX) weak_run++;
        if (weak_run >= m_weak_need) begin
          weak_run = 0;
          if (cur < cap_now) begin
            power_level = 2'(cur + 1);
            res.stepped = 1'b1;
          end
        end
      end else begin
        strong_run = 0;
        weak_run = 0;
      end
    end
    if (res.stepped) level_steps++;
    low_avg = 0;
    low_seen = 1'b0;
    res.power_index = power_level;
  endtask

  task automatic model_reset();
    m_enable      = ENABLE_RESET;
    m_cap         = CAP_RESET;
    m_strong_thr  = STRONG_THRESH_RESET;
    m_weak_thr    = WEAK_THRESH_RESET;
    m_strong_need = STRONG_ROUNDS_RESET;
    m_weak_need   = WEAK_ROUNDS_RESET;
    clear_link_state();
  endtask

  task automatic flag_result(input string what, input out_item_t want,
                             input out_item_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s at %0t: expected power_index=%0d stepped=%0b had_reading=%0b",
               what, $time, want.power_index, want.stepped, want.had_reading);
      $display("  got power_index=%0d stepped=%0b had_reading=%0b",
               got.power_index, got.stepped, got.had_reading);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    bit        due;
    out_item_t predicted;
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
        reg_writes++;
      end
      if (in_valid && !in_stall) begin
        readings_in++;
        predict_power_round(in_data, due, predicted);
        if (due) begin
          want = pin_valid ? pin_result : predicted;
          power_reports_due = {power_reports_due, want};
        end
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (power_reports_due.size() == 0) begin
          flag_result("result with none due", '0, out_data);
        end else begin
          want = power_reports_due.pop_front();
          if (out_data.power_index !== want.power_index ||
              out_data.stepped !== want.stepped ||
              out_data.had_reading !== want.had_reading) begin
            flag_result("round result mismatch", want, out_data);
          end
        end
      end
    end
  end

  // Receiver: stall patterns of varying density, plus long hold-offs
  initial begin : result_sink
    int pattern_left;
    int stall_pct;
    int hold_idx;
    int hold_at [2];
    pattern_left = 0;
    stall_pct    = 0;
    hold_idx     = 0;
    hold_at[0]   = 400;
    hold_at[1]   = 1000;
    out_stall    = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_idx < 2 && readings_in >= hold_at[hold_idx]) begin
        hold_idx++;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 5))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 10;
            3:       stall_pct = 35;
            4:       stall_pct = 65;
            default: stall_pct = 90;
          endcase
          pattern_left = $urandom_range(8, 64);
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        pattern_left--;
      end
    end
  end

  task automatic offer_reading(input in_item_t it, input bit pinned,
                               input out_item_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_data    <= it;
    pin_valid  <= pinned;
    pin_result <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold input, let every due result and the pipeline drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (power_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic script_row_t reading_row(op_t op, int slot, int rssi, bit last,
                                              bit pinned = 1'b0, out_item_t want = '0);
    script_row_t r;
    r.kind           = ROW_READING;
    r.item.op        = op;
    r.item.link_slot = 3'(slot);
    r.item.rssi_dbm  = 8'(rssi);
    r.item.round_end = last;
    r.reg_idx        = '0;
    r.reg_val        = '0;
    r.pinned         = pinned;
    r.want           = want;
    return r;
  endfunction

  function automatic script_row_t write_row(logic [2:0] idx, logic [7:0] val);
    script_row_t r;
    r.kind    = ROW_REG_WRITE;
    r.item    = '0;
    r.reg_idx = idx;
    r.reg_val = val;
    r.pinned  = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  initial begin : stimulus
    script_row_t script[$];
    stage_t      plan[$];
    stage_t      st;
    in_item_t    it;
    int          len;
    int          rssi_v;
    int          drain;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    pin_valid  = 1'b0;
    pin_result = '0;
    model_reset();

    script = {script, reading_row(OP_SAMPLE, 0, -90, 1, 1, {2'd2, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 0, 0, 1, 1, {2'd2, 1'b0, 1'b0})};
    script = {script, reading_row(OP_SAMPLE, 7, -128, 0)};
    script = {script, reading_row(OP_SAMPLE, 0, -100, 1, 1, {2'd2, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 1, 127, 0)};
    script = {script, reading_row(OP_SAMPLE, 2, -1, 1, 1, {2'd2, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 2, 127, 1, 1, {2'd2, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 3, 100, 1, 1, {2'd1, 1'b1, 1'b1})};
    script = {script, reading_row(OP_RESET, 5, 55, 1)};
    script = {script, reading_row(OP_SAMPLE, 4, -70, 1, 1, {2'd2, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 0, -60, 1, 1, {2'd2, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 5, -80, 1, 1, {2'd2, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 6, -128, 0)};
    script = {script, reading_row(OP_SAMPLE, 6, 127, 1)};
    script = {script, reading_row(OP_SAMPLE, 3, 0, 0)};
    script = {script, reading_row(OP_SAMPLE, 3, 0, 1, 1, {2'd2, 1'b0, 1'b0})};
    script = {script, write_row(REG_STRONG_ROUNDS, 8'd0)};
    script = {script, reading_row(OP_SAMPLE, 1, 50, 1, 1, {2'd1, 1'b1, 1'b1})};
    script = {script, write_row(REG_ADAPTIVE_ENABLE, 8'd0)};
    script = {script, reading_row(OP_SAMPLE, 0, -90, 1, 1, {2'd2, 1'b1, 1'b0})};
    script = {script, reading_row(OP_SAMPLE, 0, -90, 1, 1, {2'd2, 1'b0, 1'b0})};
    script = {script, write_row(REG_ADAPTIVE_ENABLE, 8'd1)};
    script = {script, write_row(REG_CAP_INDEX, 8'd3)};
    script = {script, reading_row(OP_SAMPLE, 2, -100, 1, 1, {2'd0, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 2, -100, 1, 1, {2'd0, 1'b0, 1'b1})};
    script = {script, write_row(REG_SPARE_A, 8'hFF)};
    script = {script, write_row(REG_SPARE_B, 8'hA5)};
    script = {script, write_row(REG_CAP_INDEX, 8'd1)};
    script = {script, write_row(REG_WEAK_ROUNDS, 8'd0)};
    script = {script, reading_row(OP_SAMPLE, 5, 100, 1, 1, {2'd0, 1'b1, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 6, -128, 1, 1, {2'd1, 1'b1, 1'b1})};
    script = {script, write_row(REG_STRONG_THRESH, 8'h7F)};
    script = {script, write_row(REG_WEAK_THRESH, 8'h80)};
    script = {script, reading_row(OP_SAMPLE, 1, -128, 1, 1, {2'd1, 1'b0, 1'b1})};
    script = {script, reading_row(OP_SAMPLE, 2, 127, 1, 1, {2'd1, 1'b0, 1'b1})};

    plan = {plan, stage_t'{1'b1, 2'd2, -60, -80, 3, 2, -128, 127, 60, 8, 1}};
    plan = {plan, stage_t'{1'b1, 2'd2, -65, -75, 1, 1, -95, -45, 60, 6, 1}};
    plan = {plan, stage_t'{1'b1, 2'd1, -70, -70, 2, 3, -100, -40, 50, 6, 1}};
    plan = {plan, stage_t'{1'b0, 2'd1, -70, -70, 2, 3, -128, 127, 30, 5, 2}};
    plan = {plan, stage_t'{1'b1, 2'd3, -128, 127, 1, 1, -128, 127, 30, 4, 1}};
    plan = {plan, stage_t'{1'b1, 2'd0, 127, -128, 255, 255, -128, 127, 30, 4, 1}};
    plan = {plan, stage_t'{1'b1, 2'd2, -128, 127, 255, 1, 1, 127, 260, 1, 0}};
    plan = {plan, stage_t'{1'b1, 2'd2, -60, -80, 2, 2, -128, 127, 50, 8, 1}};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG_WRITE) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer_reading(script[i].item, script[i].pinned, script[i].want);
      end
    end

    foreach (plan[p]) begin
      st = plan[p];
      settle();
      // keep the cap unless it changes: a cap transfer clears the averages, counters and power level
      if (st.cap != m_cap) write_reg(REG_CAP_INDEX, {6'($urandom), st.cap});
      write_reg(REG_ADAPTIVE_ENABLE, {7'($urandom), st.enable});
      write_reg(REG_STRONG_THRESH, 8'(st.strong_thr));
      write_reg(REG_WEAK_THRESH, 8'(st.weak_thr));
      write_reg(REG_STRONG_ROUNDS, 8'(st.strong_need));
      write_reg(REG_WEAK_ROUNDS, 8'(st.weak_need));
      repeat (st.rounds) begin
        len = $urandom_range(1, st.max_len);
        for (int k = 0; k < len; k++) begin
          it.op = ($urandom_range(0, 99) < st.reset_pct) ? OP_RESET : OP_SAMPLE;
          it.link_slot = 3'($urandom_range(0, LINK_SLOTS - 1));
          if ($urandom_range(0, 7) == 0) begin
            rssi_v = 0;
          end else begin
            do rssi_v = st.rssi_lo + int'($urandom_range(st.rssi_hi - st.rssi_lo));
            while (rssi_v == 0);
          end
          it.rssi_dbm  = 8'(rssi_v);
          it.round_end = (k == len - 1) || ($urandom_range(0, 39) == 0);
          offer_reading(it, 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    drain = 0;
    while (power_reports_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (power_reports_due.size() != 0) begin
      $display("%0d round results never arrived", power_reports_due.size());
      mismatches += power_reports_due.size();
    end

    $display("summary: %0d readings and %0d register transfers over %0d settings",
             readings_in, reg_writes, plan.size() + 1);
    $display("summary: %0d round results, %0d power steps, %0d disabled rounds",
             results_seen, level_steps, disabled_rounds);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 4);
    $display("timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
